// File: rtl/heap_sorter_top_defines.svh
// ----------------------------------------------------------------------------
// heap sorter assertion macros
// shared concurrent check forms for the heap sorter rtl
// ----------------------------------------------------------------------------
`ifndef HEAP_SORTER_TOP_DEFINES_SVH
`define HEAP_SORTER_TOP_DEFINES_SVH

// same-cycle implication
`define HS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("heap sorter check failed");

// next-cycle implication
`define HS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("heap sorter check failed");

`endif

// File: rtl/hs_pkg.sv
// ----------------------------------------------------------------------------
// heap sorter package
// shared constants and cell control type
// ----------------------------------------------------------------------------
package hs_pkg;

    localparam int HS_MAX_ITEMS = 16;
    localparam int HS_DATA_W    = 32;

    typedef struct packed {
        logic                        insert;
        logic                        pop;
        logic signed [HS_DATA_W-1:0] new_value;
    } hs_cell_ctrl_t;

endpackage

// File: rtl/heap_sorter_top.sv
// load: one element per cycle while loading, held in an ordered row of cells
// the transaction marked last switches to drain; the head cell is then registered to the output
// a set drains smallest first as outputs are taken; input is held off while the row drains
// a set holds up to MAX_ITEMS elements; later ones are dropped and m_dropped is set
// reset: synchronous active-low aresetn empties every cell and clears the overflow flag
// ----------------------------------------------------------------------------
// heap sorter top
// collects a set of signed values and returns them in ascending order
// ----------------------------------------------------------------------------
`include "heap_sorter_top_defines.svh"

module heap_sorter_top
    import hs_pkg::*;
#(
    parameter int MAX_ITEMS = HS_MAX_ITEMS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [HS_DATA_W-1:0] s_value,
    input  logic                        s_is_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [HS_DATA_W-1:0] m_sorted_value,
    output logic                        m_last_out,
    output logic                        m_dropped
);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } hs_state_t;

    hs_state_t state_reg, state_next;
    logic      overflow_reg, overflow_next;

    logic                        m_valid_reg;
    logic signed [HS_DATA_W-1:0] m_sorted_value_reg;
    logic                        m_last_out_reg;
    logic                        m_dropped_reg;

    logic signed [HS_DATA_W-1:0] cell_value [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]        cell_valid;
    logic [MAX_ITEMS-1:0]        cell_ins;

    hs_cell_ctrl_t ctrl;
    logic          accept;
    logic          full;
    logic          load_out;
    logic          pop_last;

    assign s_ready  = (state_reg == ST_LOAD);
    assign accept   = s_valid && s_ready;
    assign full     = cell_valid[MAX_ITEMS-1];
    assign load_out = (state_reg == ST_DRAIN) && (!m_valid_reg || m_ready);
    assign pop_last = load_out && !cell_valid[1];

    assign ctrl.insert    = accept && !full;
    assign ctrl.pop       = load_out;
    assign ctrl.new_value = s_value;

    // ordered row, smallest value in cell 0
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        logic signed [HS_DATA_W-1:0] lv;
        logic                        lval;
        logic                        lins;
        logic signed [HS_DATA_W-1:0] rv;
        logic                        rval;

        if (i == 0) begin : g_first
            assign lv   = '0;
            assign lval = 1'b0;
            assign lins = 1'b0;
        end else begin : g_mid
            assign lv   = cell_value[i-1];
            assign lval = cell_valid[i-1];
            assign lins = cell_ins[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_end
            assign rv   = '0;
            assign rval = 1'b0;
        end else begin : g_inner
            assign rv   = cell_value[i+1];
            assign rval = cell_valid[i+1];
        end

        hs_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .left_value  (lv),
            .left_valid  (lval),
            .left_ins    (lins),
            .right_value (rv),
            .right_valid (rval),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .ins         (cell_ins[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    overflow_next = overflow_reg | full;
                    if (s_is_last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (pop_last) begin
                    state_next    = ST_LOAD;
                    overflow_next = 1'b0;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (load_out) begin
            m_sorted_value_reg <= cell_value[0];
            m_last_out_reg     <= !cell_valid[1];
            m_dropped_reg      <= overflow_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_sorted_value_reg;
    assign m_last_out     = m_last_out_reg;
    assign m_dropped      = m_dropped_reg;

    `HS_ASSERT_NOW(a_valid_prefix, aclk, aresetn, 1'b1,
        (((cell_valid + MAX_ITEMS'(1)) & cell_valid) == '0))
    `HS_ASSERT_NOW(a_drain_nonempty, aclk, aresetn, state_reg == ST_DRAIN, cell_valid[0])
    `HS_ASSERT_NEXT(a_last_starts_drain, aclk, aresetn, accept && s_is_last,
        state_reg == ST_DRAIN)

endmodule

// File: rtl/hs_cell.sv
// ----------------------------------------------------------------------------
// heap sorter cell
// one slot of the ordered row: shifts right on insert, left on pop
// ----------------------------------------------------------------------------
module hs_cell
    import hs_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hs_cell_ctrl_t               ctrl,
    input  logic signed [HS_DATA_W-1:0] left_value,
    input  logic                        left_valid,
    input  logic                        left_ins,
    input  logic signed [HS_DATA_W-1:0] right_value,
    input  logic                        right_valid,
    output logic signed [HS_DATA_W-1:0] value,
    output logic                        valid,
    output logic                        ins
);

    logic signed [HS_DATA_W-1:0] value_reg;
    logic signed [HS_DATA_W-1:0] value_next;
    logic                        valid_reg;
    logic                        valid_next;

    assign ins   = !valid_reg || (ctrl.new_value < value_reg);
    assign value = value_reg;
    assign valid = valid_reg;

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert && ins) begin
            if (left_ins) begin
                value_next = left_value;
                valid_next = left_valid;
            end else begin
                value_next = ctrl.new_value;
                valid_next = 1'b1;
            end
        end else if (ctrl.pop) begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
    end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// heap sorter testbench
// sends sets of signed values, short and full and past capacity, and checks
// each returned value, end marker and dropped flag against a sorted copy of
// the set kept here, with random idle bursts on both channels
// ----------------------------------------------------------------------------
module tb;
    import hs_pkg::*;

    localparam int RUN_ITEMS   = 460;
    localparam int CALM_ITEMS  = 80;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 300000;

    localparam logic signed [HS_DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [HS_DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [HS_DATA_W-1:0] value;
        logic                        last;
    } element_t;

    typedef struct {
        logic signed [HS_DATA_W-1:0] value;
        logic                        last;
        logic                        dropped;
    } sorted_t;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    logic signed [HS_DATA_W-1:0] s_value   = '0;
    logic                        s_is_last = 1'b0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    logic signed [HS_DATA_W-1:0] m_sorted_value;
    logic                        m_last_out;
    logic                        m_dropped;

    element_t                    feed_q[$];
    sorted_t                     sorted_due[$];
    logic signed [HS_DATA_W-1:0] set_buf[$];
    logic                        set_overflow = 1'b0;

    element_t next_elem;
    sorted_t  want;
    int       gap_left   = 0;
    int       stall_left = 0;
    int       gen_len    = 0;
    int       sets_total = 0;
    int       sets_over  = 0;
    int       checked    = 0;
    int       fail_count = 0;
    int       cycles     = 0;

    heap_sorter_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_is_last      (s_is_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_last_out     (m_last_out),
        .m_dropped      (m_dropped)
    );

    always #2 aclk = ~aclk;

    // no idling once the feed is nearly drained
    function automatic bit calm();
        return feed_q.size() < CALM_ITEMS;
    endfunction

    // stores an element or sets overflow; the closing one sorts and queues the set
    task automatic load_element(input logic signed [HS_DATA_W-1:0] v, input logic last);
        logic signed [HS_DATA_W-1:0] tmp;
        int j;
        sorted_t r;
        if (set_buf.size() < HS_MAX_ITEMS)
            set_buf.push_back(v);
        else
            set_overflow = 1'b1;
        if (last) begin
            for (int i = 1; i < set_buf.size(); i++) begin
                tmp = set_buf[i];
                j = i - 1;
                while (j >= 0 && set_buf[j] > tmp) begin
                    set_buf[j + 1] = set_buf[j];
                    j--;
                end
                set_buf[j + 1] = tmp;
            end
            for (int k = 0; k < set_buf.size(); k++) begin
                r.value   = set_buf[k];
                r.last    = (k == set_buf.size() - 1);
                r.dropped = set_overflow;
                sorted_due.push_back(r);
            end
            set_buf.delete();
            set_overflow = 1'b0;
        end
    endtask

    task automatic push_item(input logic signed [HS_DATA_W-1:0] v, input logic last);
        element_t e;
        e.value = v;
        e.last  = last;
        feed_q.push_back(e);
        gen_len++;
        if (last) begin
            sets_total++;
            if (gen_len > HS_MAX_ITEMS)
                sets_over++;
            gen_len = 0;
        end
    endtask

    function automatic logic signed [HS_DATA_W-1:0] pick_value();
        logic signed [HS_DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = VAL_MAX;
                    1: v = VAL_MIN;
                    2: v = '0;
                    default: v = -1;
                endcase
            end
            1: v = $signed($urandom_range(0, 8)) - 4;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic push_set(input int n);
        for (int i = 0; i < n; i++)
            push_item(pick_value(), i == n - 1);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready)
                load_element(s_value, s_is_last);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (feed_q.size() > 0) begin
                    next_elem = feed_q.pop_front();
                    s_valid   <= 1'b1;
                    s_value   <= next_elem.value;
                    s_is_last <= next_elem.last;
                    if (!calm() && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 10);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (sorted_due.size() == 0) begin
                    $error("unexpected transaction, sorted_value %0d", m_sorted_value);
                    fail_count++;
                end else begin
                    want = sorted_due.pop_front();
                    checked++;
                    if (m_sorted_value !== want.value) begin
                        $error("sorted_value: expected %0d, got %0d", want.value,
                               m_sorted_value);
                        fail_count++;
                    end
                    if (m_last_out !== want.last) begin
                        $error("last_out: expected %0b, got %0b", want.last, m_last_out);
                        fail_count++;
                    end
                    if (m_dropped !== want.dropped) begin
                        $error("dropped: expected %0b, got %0b", want.dropped, m_dropped);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm() && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 10);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int pick;
        // single elements at both extremes
        push_item(VAL_MAX, 1'b1);
        push_item(VAL_MIN, 1'b1);
        // mixed signs and boundaries
        push_item('0, 1'b0);
        push_item(-1, 1'b0);
        push_item(VAL_MAX, 1'b0);
        push_item(VAL_MIN, 1'b0);
        push_item(1, 1'b1);
        // equal values
        push_item(7, 1'b0);
        push_item(7, 1'b0);
        push_item(-7, 1'b0);
        push_item(7, 1'b1);
        // two elements in descending order
        push_item(VAL_MAX, 1'b0);
        push_item(VAL_MIN, 1'b1);

        while (feed_q.size() < RUN_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                push_set($urandom_range(1, HS_MAX_ITEMS));
            else if (pick < 17)
                push_set(HS_MAX_ITEMS);
            else
                push_set($urandom_range(HS_MAX_ITEMS + 1, HS_MAX_ITEMS + 6));
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (feed_q.size() > 0 || s_valid || sorted_due.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d sets (%0d past capacity), checked %0d sorted values",
                 sets_total, sets_over, checked);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
